FILE: rtl/core/version_banner_scan_parse_unit_defines.svh
// assertion helpers for the checker file
`ifndef VERSION_BANNER_SCAN_PARSE_UNIT_DEFINES_SVH
`define VERSION_BANNER_SCAN_PARSE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while reset is applied
`define VBSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vbsp: same-cycle check failed");

// next-cycle implication, sampled on clk, off while reset is applied
`define VBSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vbsp: next-cycle check failed");

`endif

FILE: rtl/core/vbsp_pkg.sv
package vbsp_pkg;

	// banner and field geometry
	localparam int BANNER_LEN        = 22;
	localparam int FIELD_BUFFER_SIZE = 32;
	localparam int PART_COUNT        = 3;

	localparam int VER_W  = 20;
	localparam int POS_W  = $clog2(BANNER_LEN);
	localparam int CNT_W  = $clog2(FIELD_BUFFER_SIZE);
	localparam int PART_W = $clog2(PART_COUNT + 1);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// register select bit of the config port
	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef enum logic [2:0] {
		PH_SEARCH  = 3'b001,
		PH_COLLECT = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [VER_W-1:0] version;
		logic             found;
		logic             in_range;
	} res_t;

	// banner text, one byte per position
	function automatic logic [7:0] banner_char(input logic [POS_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = 8'h44;
			5'd1:    c = 8'h61;
			5'd2:    c = 8'h72;
			5'd3:    c = 8'h77;
			5'd4:    c = 8'h69;
			5'd5:    c = 8'h6E;
			5'd6:    c = 8'h20;
			5'd7:    c = 8'h4B;
			5'd8:    c = 8'h65;
			5'd9:    c = 8'h72;
			5'd10:   c = 8'h6E;
			5'd11:   c = 8'h65;
			5'd12:   c = 8'h6C;
			5'd13:   c = 8'h20;
			5'd14:   c = 8'h56;
			5'd15:   c = 8'h65;
			5'd16:   c = 8'h72;
			5'd17:   c = 8'h73;
			5'd18:   c = 8'h69;
			5'd19:   c = 8'h6F;
			5'd20:   c = 8'h6E;
			5'd21:   c = 8'h20;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// decimal weight of a part: 100 to the power of the parts after it
	function automatic logic [VER_W-1:0] part_weight(input logic [PART_W-1:0] idx);
		logic [VER_W-1:0] w;
		w = VER_W'(1);
		for (int i = 0; i < PART_COUNT - 1; i++) begin
			if (int'(idx) <= i) begin
				w = VER_W'(w * VER_W'(100));
			end
		end
		return w;
	endfunction

endpackage

FILE: rtl/core/vbsp_scan.sv
module vbsp_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    data_byte,
	input  logic                          last,
	input  logic [vbsp_pkg::VER_W-1:0]    min_version,
	input  logic [vbsp_pkg::VER_W-1:0]    max_version,
	output vbsp_pkg::res_t                res
);

	vbsp_pkg::phase_t                    phase_q, phase_d;
	logic [vbsp_pkg::POS_W-1:0]          match_q, match_d;
	logic [vbsp_pkg::CNT_W-1:0]          count_q, count_d;
	logic [vbsp_pkg::PART_W-1:0]         part_q, part_d;
	logic                                digit_q, digit_d;
	logic [3:0]                          first_q, first_d;
	logic [vbsp_pkg::VER_W-1:0]          acc_q, acc_d;
	logic                                failed_q, failed_d;
	logic                                dot_q, dot_d;
	logic                                fin_q, fin_d;

	logic                                is_digit;
	logic [3:0]                          digit_val;
	logic [6:0]                          delta;
	logic                                parse_live;
	logic                                failed_end;
	logic                                found;
	logic [vbsp_pkg::VER_W-1:0]          ver;

	assign is_digit  = (data_byte >= vbsp_pkg::CH_ZERO) && (data_byte <= vbsp_pkg::CH_NINE);
	assign digit_val = data_byte[3:0];
	assign parse_live = !failed_q && !fin_q
		&& (part_q < vbsp_pkg::PART_W'(vbsp_pkg::PART_COUNT));

	// contribution of a digit: the accumulator always carries the open part
	assign delta = digit_q ? (7'(first_q) * 7'd9 + 7'(digit_val)) : 7'(digit_val);

	// next state for one byte
	always_comb begin
		phase_d  = phase_q;
		match_d  = match_q;
		count_d  = count_q;
		part_d   = part_q;
		digit_d  = digit_q;
		first_d  = first_q;
		acc_d    = acc_q;
		failed_d = failed_q;
		dot_d    = dot_q;
		fin_d    = fin_q;
		unique case (phase_q)
			vbsp_pkg::PH_SEARCH: begin
				if (data_byte == vbsp_pkg::banner_char(match_q)) begin
					if (match_q == vbsp_pkg::POS_W'(vbsp_pkg::BANNER_LEN - 1)) begin
						phase_d = vbsp_pkg::PH_COLLECT;
						match_d = '0;
					end else begin
						match_d = match_q + 1'b1;
					end
				end else if (data_byte == vbsp_pkg::banner_char('0)) begin
					match_d = vbsp_pkg::POS_W'(1);
				end else begin
					match_d = '0;
				end
			end
			vbsp_pkg::PH_COLLECT: begin
				if (data_byte == vbsp_pkg::CH_COLON) begin
					if (count_q == '0) begin
						failed_d = 1'b1;
					end
					phase_d = vbsp_pkg::PH_DONE;
				end else begin
					if (parse_live) begin
						if (count_q == '0 && !is_digit) begin
							failed_d = 1'b1;
						end else if (data_byte == vbsp_pkg::CH_NUL) begin
							fin_d = 1'b1;
							dot_d = 1'b0;
						end else if (dot_q && data_byte == vbsp_pkg::CH_DOT) begin
							// dot right after a two-digit part is skipped
							dot_d = 1'b0;
						end else begin
							dot_d = 1'b0;
							if (is_digit) begin
								acc_d = acc_q + vbsp_pkg::VER_W'(vbsp_pkg::VER_W'(delta)
									* vbsp_pkg::part_weight(part_q));
								if (!digit_q) begin
									first_d = digit_val;
									digit_d = 1'b1;
								end else begin
									part_d  = part_q + 1'b1;
									digit_d = 1'b0;
									dot_d   = (part_d < vbsp_pkg::PART_W'(vbsp_pkg::PART_COUNT));
								end
							end else if (data_byte == vbsp_pkg::CH_DOT) begin
								part_d  = part_q + 1'b1;
								digit_d = 1'b0;
							end else begin
								failed_d = 1'b1;
							end
						end
					end
					count_d = count_q + 1'b1;
					if (count_d == vbsp_pkg::CNT_W'(vbsp_pkg::FIELD_BUFFER_SIZE - 1)) begin
						phase_d = vbsp_pkg::PH_DONE;
					end
				end
			end
			vbsp_pkg::PH_DONE: begin
			end
			default: begin
				phase_d = vbsp_pkg::PH_SEARCH;
			end
		endcase
	end

	// result for a last byte
	assign failed_end = failed_d || (phase_d == vbsp_pkg::PH_COLLECT && count_d == '0);
	assign found      = (phase_d != vbsp_pkg::PH_SEARCH);
	assign ver        = (found && !failed_end) ? acc_d : '0;

	always_comb begin
		res.version = ver;
		res.found   = found;
		if (ver == '0) begin
			res.in_range = (max_version == '0);
		end else begin
			res.in_range = (ver >= min_version) && ((max_version == '0) || (ver <= max_version));
		end
	end

	// scan state, rearmed after the last byte of an image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= vbsp_pkg::PH_SEARCH;
			match_q  <= '0;
			count_q  <= '0;
			part_q   <= '0;
			digit_q  <= 1'b0;
			first_q  <= '0;
			acc_q    <= '0;
			failed_q <= 1'b0;
			dot_q    <= 1'b0;
			fin_q    <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q  <= vbsp_pkg::PH_SEARCH;
				match_q  <= '0;
				count_q  <= '0;
				part_q   <= '0;
				digit_q  <= 1'b0;
				first_q  <= '0;
				acc_q    <= '0;
				failed_q <= 1'b0;
				dot_q    <= 1'b0;
				fin_q    <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				match_q  <= match_d;
				count_q  <= count_d;
				part_q   <= part_d;
				digit_q  <= digit_d;
				first_q  <= first_d;
				acc_q    <= acc_d;
				failed_q <= failed_d;
				dot_q    <= dot_d;
				fin_q    <= fin_d;
			end
		end
	end

endmodule

FILE: rtl/core/version_banner_scan_parse_unit.sv
// Banner scan and version parse unit.
// Input channel: one image byte per beat (data_byte, last) on in_valid/in_stall.
// The unit hunts for the fixed 22-byte banner, then reads the dotted version
// field after it (up to three parts of two digits, ended by a colon, a zero
// byte, 31 bytes or the image end) and packs it as part1*10000+part2*100+part3.
// Output channel: one beat per image (version, found, in_range) on
// out_valid/out_stall, issued for the beat that carries last.
// A last beat passes the input register, then the result register, before
// out_valid rises. Throughput: one byte per cycle while in_stall is low; the
// scan state is updated by byte compares and a small constant multiply-add.
// Receiver stall: the result register holds its beat; further non-last bytes
// keep flowing, and in_stall rises only when a second result is ready and the
// first has not been taken.
// Config: APB at byte address 0 (min_version) and 4 (max_version); write only
// while idle. Reset clears the scan state, both limits and both valids.
module version_banner_scan_parse_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [vbsp_pkg::VER_W-1:0]      version,
	output logic                            found,
	output logic                            in_range,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vbsp_pkg::ADDR_W-1:0]     paddr,
	input  logic [vbsp_pkg::DATA_W-1:0]     pwdata,
	output logic [vbsp_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	logic                            valid_s1;
	logic [7:0]                      byte_s1;
	logic                            last_s1;
	logic                            s1_go;
	logic                            in_accept;
	logic                            cfg_write;

	logic [vbsp_pkg::VER_W-1:0]      min_q;
	logic [vbsp_pkg::VER_W-1:0]      max_q;

	logic                            out_valid_q;
	vbsp_pkg::res_t                  res;
	vbsp_pkg::res_t                  res_q;

	// handshake: the input register moves unless it holds a result with nowhere to go
	assign s1_go     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_go;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	vbsp_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_go),
		.data_byte   (byte_s1),
		.last        (last_s1),
		.min_version (min_q),
		.max_version (max_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign version   = res_q.version;
	assign found     = res_q.found;
	assign in_range  = res_q.in_range;

	// config registers
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				vbsp_pkg::REG_MIN: min_q <= pwdata[vbsp_pkg::VER_W-1:0];
				vbsp_pkg::REG_MAX: max_q <= pwdata[vbsp_pkg::VER_W-1:0];
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (paddr[2])
			vbsp_pkg::REG_MIN: prdata = vbsp_pkg::DATA_W'(min_q);
			vbsp_pkg::REG_MAX: prdata = vbsp_pkg::DATA_W'(max_q);
		endcase
	end

endmodule

FILE: rtl/core/vbsp_check.sv
`include "version_banner_scan_parse_unit_defines.svh"

module vbsp_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [vbsp_pkg::VER_W-1:0]      version,
	input  logic                            found,
	input  logic                            in_range
);

	// a stalled result beat stays up
	`VBSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// a stalled result beat keeps its payload
	`VBSP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({version, found, in_range}))

	// input back-pressure only comes from a held result beat
	`VBSP_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)

	// no banner means no version
	`VBSP_ASSERT_NOW(a_no_banner, out_valid && !found, version == '0)

endmodule

bind version_banner_scan_parse_unit vbsp_check u_vbsp_check (.*);

FILE: tb/sv/version_banner_scan_parse_unit_tb.sv
`timescale 1ns / 1ps

module version_banner_scan_parse_unit_tb;
	import vbsp_pkg::*;

	typedef struct packed {
		logic [VER_W-1:0] version;
		logic             found;
		logic             in_range;
	} scan_report_t;

	// banner text as hex, first character in the top byte
	localparam logic [8*BANNER_LEN-1:0] BANNER_BYTES =
		176'h44617277_696E204B_65726E65_6C205665_7273696F_6E20;
	localparam logic [ADDR_W-1:0] MIN_ADDR = ADDR_W'({REG_MIN, 2'b00});
	localparam logic [ADDR_W-1:0] MAX_ADDR = ADDR_W'({REG_MAX, 2'b00});
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_BYTES  = 160;
	localparam int LIMIT_NS      = 4_000_000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte = 8'h00;
	logic              last      = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VER_W-1:0]  version;
	logic              found;
	logic              in_range;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// predicted scan state and limits
	phase_t           scan_phase;
	int               match_pos;
	int               field_len;
	int               part_idx;
	int               digit_idx;
	int               part_val;
	logic [VER_W-1:0] ver_acc;
	logic             field_bad;
	logic             dot_skip;
	logic [VER_W-1:0] lim_min;
	logic [VER_W-1:0] lim_max;

	scan_report_t report_queue[$];
	logic [7:0]   img[$];

	int gap_pct     = 0;
	int stall_pct   = 0;
	int stall_hold  = 0;
	int errors      = 0;
	int bytes_sent  = 0;
	int images_sent = 0;
	int beats_seen  = 0;
	int found_seen  = 0;
	int cfg_writes  = 0;

	version_banner_scan_parse_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.version   (version),
		.found     (found),
		.in_range  (in_range),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [7:0] banner_at(input int idx);
		return BANNER_BYTES[8*(BANNER_LEN-1-idx) +: 8];
	endfunction

	function automatic void clear_scan_state();
		scan_phase = PH_SEARCH;
		match_pos  = 0;
		field_len  = 0;
		part_idx   = 0;
		digit_idx  = 0;
		part_val   = 0;
		ver_acc    = '0;
		field_bad  = 1'b0;
		dot_skip   = 1'b0;
	endfunction

	function automatic void seal_part();
		ver_acc   = VER_W'(ver_acc * 100 + part_val);
		part_val  = 0;
		digit_idx = 0;
		part_idx++;
	endfunction

	// missing parts count as zero
	function automatic void seal_all_parts();
		while (part_idx < PART_COUNT)
			seal_part();
		dot_skip = 1'b0;
	endfunction

	function automatic void take_field_char(input logic [7:0] c);
		logic is_digit;
		int   d;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (field_bad || part_idx >= PART_COUNT)
			return;
		if (field_len == 0 && !is_digit) begin
			field_bad = 1'b1;
			return;
		end
		if (c == CH_NUL) begin
			seal_all_parts();
			return;
		end
		// a dot right after a two-digit part is only a separator
		if (dot_skip) begin
			dot_skip = 1'b0;
			if (c == CH_DOT)
				return;
		end
		if (is_digit) begin
			d = int'(c - CH_ZERO);
			if (digit_idx == 0) begin
				part_val  = d;
				digit_idx = 1;
			end else begin
				part_val = part_val * 10 + d;
				seal_part();
				if (part_idx < PART_COUNT)
					dot_skip = 1'b1;
			end
		end else if (c == CH_DOT) begin
			seal_part();
		end else begin
			field_bad = 1'b1;
		end
	endfunction

	function automatic void end_of_field();
		if (field_len == 0)
			field_bad = 1'b1;
		else
			seal_all_parts();
	endfunction

	// advance the scan by one accepted beat, queue the report on the last one
	function automatic void scan_step(input logic [7:0] b, input logic is_last);
		int           pos;
		scan_report_t rep;
		if (scan_phase == PH_SEARCH) begin
			pos = (match_pos < BANNER_LEN) ? match_pos : 0;
			if (b == banner_at(pos)) begin
				pos++;
				if (pos >= BANNER_LEN) begin
					scan_phase = PH_COLLECT;
					pos = 0;
				end
			end else begin
				pos = (b == banner_at(0)) ? 1 : 0;
			end
			match_pos = pos;
		end else if (scan_phase == PH_COLLECT) begin
			if (b == CH_COLON) begin
				end_of_field();
				scan_phase = PH_DONE;
			end else begin
				take_field_char(b);
				field_len++;
				if (field_len >= FIELD_BUFFER_SIZE - 1) begin
					end_of_field();
					scan_phase = PH_DONE;
				end
			end
		end
		if (!is_last)
			return;
		if (scan_phase == PH_COLLECT) begin
			end_of_field();
			scan_phase = PH_DONE;
		end
		rep.found   = (scan_phase != PH_SEARCH);
		rep.version = (rep.found && !field_bad) ? ver_acc : '0;
		// a zero version counts as infinite
		if (rep.version == 0)
			rep.in_range = (lim_max == 0);
		else
			rep.in_range = (rep.version >= lim_min) &&
				(lim_max == 0 || rep.version <= lim_max);
		report_queue.push_back(rep);
		clear_scan_state();
	endfunction

	// ---------------------------------------------------------------- drivers

	// receiver: random stall, or a long counted hold when requested
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			out_stall  <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
		end
	end

	// result check against the oldest predicted report
	always @(posedge clk) begin : check_reports
		scan_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (report_queue.size() == 0) begin
				$error("unexpected result beat: version %0d found %0b in_range %0b",
					version, found, in_range);
				errors++;
			end else begin
				want = report_queue.pop_front();
				beats_seen++;
				if (found === 1'b1)
					found_seen++;
				if (version !== want.version) begin
					$error("version mismatch: expected %0d, got %0d", want.version, version);
					errors++;
				end
				if (found !== want.found) begin
					$error("found mismatch: expected %0b, got %0b", want.found, found);
					errors++;
				end
				if (in_range !== want.in_range) begin
					$error("in_range mismatch: expected %0b, got %0b",
						want.in_range, in_range);
					errors++;
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic is_last);
		while (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last      <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		scan_step(b, is_last);
		bytes_sent++;
	endtask

	task automatic send_image();
		for (int i = 0; i < img.size(); i++)
			push_byte(img[i], i == img.size() - 1);
		img.delete();
		images_sent++;
	endtask

	// drain all owed reports, then let the pipeline settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (report_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [VER_W-1:0] value);
		logic [DATA_W-1:0] word;
		word = $urandom;
		word[VER_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == MIN_ADDR)
			lim_min = value;
		else
			lim_max = value;
		cfg_writes++;
	endtask

	task automatic set_limits(input logic [VER_W-1:0] lo, input logic [VER_W-1:0] hi);
		wait_quiet();
		write_reg(MIN_ADDR, lo);
		write_reg(MAX_ADDR, hi);
	endtask

	// ---------------------------------------------------------------- image builders

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			img.push_back(s[i]);
	endtask

	task automatic add_banner_head(input int n);
		for (int i = 0; i < n; i++)
			img.push_back(banner_at(i));
	endtask

	task automatic add_banner();
		add_banner_head(BANNER_LEN);
	endtask

	// random bytes, now and then the banner's first letter
	task automatic add_noise(input int n);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				img.push_back(banner_at(0));
			else
				img.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_part(input int val);
		if (val >= 10 || $urandom_range(0, 1) == 1)
			img.push_back(CH_ZERO + 8'(val / 10));
		img.push_back(CH_ZERO + 8'(val % 10));
	endtask

	task automatic add_dotted_field(input int nparts);
		for (int i = 0; i < nparts; i++) begin
			if (i > 0)
				img.push_back(CH_DOT);
			add_part($urandom_range(0, 99));
			if ($urandom_range(0, 9) == 0)
				img.push_back(CH_DOT);
		end
	endtask

	task automatic add_version(input int v);
		add_part(v / 10000);
		img.push_back(CH_DOT);
		add_part((v / 100) % 100);
		img.push_back(CH_DOT);
		add_part(v % 100);
	endtask

	function automatic logic [7:0] field_soup();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return CH_ZERO + 8'($urandom_range(0, 9));
		else if (r < 70)
			return CH_DOT;
		else if (r < 75)
			return CH_COLON;
		else if (r < 80)
			return CH_NUL;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic build_random_image();
		int kind;
		int start;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			// banner and dotted field with random content, now and then one field byte overwritten
			add_noise($urandom_range(0, 4));
			if ($urandom_range(0, 3) == 0) begin
				add_banner_head($urandom_range(1, BANNER_LEN - 1));
				add_noise(1);
			end
			add_banner();
			start = img.size();
			add_dotted_field($urandom_range(1, PART_COUNT));
			if ($urandom_range(0, 6) == 0)
				img[$urandom_range(start, img.size() - 1)] = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0: img.push_back(CH_COLON);
				1: img.push_back(CH_NUL);
				2: ;
				default: add_noise($urandom_range(1, 3));
			endcase
			add_noise($urandom_range(0, 3));
		end else if (kind < 75) begin
			add_noise($urandom_range(1, 8));
		end else if (kind < 85) begin
			add_banner();
			repeat ($urandom_range(0, 36))
				img.push_back(field_soup());
		end else if (kind < 92) begin
			// broken banner, sometimes followed by a good one
			add_banner_head($urandom_range(1, BANNER_LEN - 1));
			add_noise($urandom_range(1, 2));
			if ($urandom_range(0, 1) == 1) begin
				add_banner();
				add_dotted_field($urandom_range(1, PART_COUNT));
			end
		end else begin
			// two banners: only the first one counts
			add_banner();
			add_dotted_field($urandom_range(1, PART_COUNT));
			img.push_back(CH_COLON);
			add_noise($urandom_range(0, 2));
			add_banner();
			add_dotted_field($urandom_range(1, PART_COUNT));
		end
		if (img.size() == 0)
			add_noise(1);
	endtask

	function automatic logic [VER_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VER_W'(1);
			2: return VER_W'(999999);
			3: return '1;
			default: return VER_W'($urandom_range(0, 999999));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic run_directed_images();
		gap_pct   = 0;
		stall_pct = 0;
		// lone bytes at both ends of the range, no banner
		img.push_back(8'h00);
		send_image();
		img.push_back(8'hFF);
		send_image();
		// banner ends on the last byte: empty field
		add_banner();
		send_image();
		// field ended by the image end
		add_banner();
		add_text("1.2.3");
		send_image();
		// largest version, then trailing bytes ignored
		add_banner();
		add_text("99.99.99:7q");
		send_image();
		// colon right after the banner
		add_banner();
		img.push_back(CH_COLON);
		send_image();
		// first field byte not a digit
		add_banner();
		add_text("a1.2:");
		send_image();
		// bad character inside a part
		add_banner();
		add_text("1.x2:");
		send_image();
		// zero byte ends the field
		add_banner();
		add_text("12.3");
		img.push_back(CH_NUL);
		add_text("45");
		send_image();
		// separator dot skipped after two digits, second dot closes an empty part
		add_banner();
		add_text("12..5:");
		send_image();
		// field length limit
		add_banner();
		add_text("1234567890123456789012345678901");
		add_text("99");
		send_image();
		// repeated first letter restarts the match
		img.push_back(banner_at(0));
		add_banner();
		add_text("3");
		send_image();
		// mismatch deep in the banner on its first letter
		add_banner_head(7);
		add_banner();
		add_text("4.5:");
		send_image();
		// second banner ignored
		add_banner();
		add_text("1:");
		add_banner();
		add_text("2:");
		send_image();
		// all-zero version
		add_banner();
		add_text("0.0.0:");
		send_image();
		// zero byte as first field byte
		add_banner();
		img.push_back(CH_NUL);
		send_image();
		// one digit then a zero byte
		add_banner();
		add_text("5");
		img.push_back(CH_NUL);
		send_image();
		// near miss on the final banner character
		add_banner_head(BANNER_LEN - 1);
		add_text("x1.2");
		send_image();
	endtask

	task automatic run_range_limits();
		logic [VER_W-1:0] lo_set[4] = '{VER_W'(10000), VER_W'(1), '1, VER_W'(50505)};
		logic [VER_W-1:0] hi_set[4] = '{VER_W'(20000), VER_W'(0), VER_W'(0), VER_W'(50505)};
		int probe[3];
		gap_pct   = 16;
		stall_pct = 16;
		for (int s = 0; s < 4; s++) begin
			set_limits(lo_set[s], hi_set[s]);
			probe = '{int'(lo_set[s]) - 1, int'(lo_set[s]), int'(hi_set[s]) + 1};
			foreach (probe[k]) begin
				if (probe[k] >= 1 && probe[k] <= 999999) begin
					add_noise($urandom_range(0, 2));
					add_banner();
					add_version(probe[k]);
					img.push_back(CH_COLON);
					send_image();
				end
			end
			// zero version and missing banner under the same limits
			add_banner();
			img.push_back(CH_COLON);
			send_image();
			add_noise(3);
			send_image();
		end
	endtask

	task automatic run_random_traffic();
		int gap_mix[4]   = '{0, 49, 0, 16};
		int stall_mix[4] = '{0, 0, 49, 16};
		int first_byte;
		int first_image;
		for (int p = 0; p < 4; p++) begin
			for (int blk = 0; blk < 2; blk++) begin
				wait_quiet();
				gap_pct   = gap_mix[p];
				stall_pct = stall_mix[p];
				lim_min   = pick_limit();
				lim_max   = pick_limit();
				if ($urandom_range(0, 1) == 1 && lim_min > lim_max && lim_max != 0)
					set_limits(lim_max, lim_min);
				else
					set_limits(lim_min, lim_max);
				first_byte  = bytes_sent;
				first_image = images_sent;
				while (bytes_sent - first_byte < RANDOM_BYTES / 8 ||
						images_sent - first_image < 1) begin
					build_random_image();
					send_image();
				end
			end
		end
	endtask

	task automatic run_backpressure();
		wait_quiet();
		gap_pct    = 0;
		stall_pct  = 0;
		stall_hold = HOLD_CYCLES;
		// short images pile up results behind the held receiver
		repeat (8) begin
			if ($urandom_range(0, 3) == 0) begin
				add_banner();
				add_text("9.8");
			end else begin
				add_noise($urandom_range(1, 2));
			end
			send_image();
		end
		// sender waits for every report before going on
		wait_quiet();
	endtask

	initial begin
		clear_scan_state();
		lim_min = '0;
		lim_max = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed_images();
		run_range_limits();
		run_random_traffic();
		run_backpressure();
		wait_quiet();
		repeat (8) @(posedge clk);

		$display("covered %0d bytes in %0d images; %0d result beats checked, %0d with banner",
			bytes_sent, images_sent, beats_seen, found_seen);
		$display("%0d limit writes, idle mixes on both sides and one long receiver hold",
			cfg_writes);
		if (errors == 0 && report_queue.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/vbsp_pkg.sv
rtl/core/vbsp_scan.sv
rtl/core/version_banner_scan_parse_unit.sv
rtl/core/vbsp_check.sv
tb/sv/version_banner_scan_parse_unit_tb.sv
